// ===== rtl/stag_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stag_pkg: shared types and constants
// Opcodes, status codes, register indexes and default sizes of the strided
// tensor address generator.
// ---------------------------------------------------------------------------
package stag_pkg;

  localparam int unsigned MaxDimsDefault    = 8;
  localparam int unsigned OffsetBitsDefault = 48;

  localparam int unsigned ExtW = 32;
  localparam int unsigned FldW = 48;
  localparam int unsigned CfgW = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpXlate  = 2'd1;
  localparam logic [1:0] OpMake   = 2'd2;
  localparam logic [1:0] OpCheck  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StOverflow = 2'd1;
  localparam logic [1:0] StDimErr   = 2'd2;

  localparam logic [CfgIdxW-1:0] RegDimCount = 1'd0;
  localparam logic [CfgIdxW-1:0] RegElemLog2 = 1'd1;

  // Request and response between the sequencer and the divider.
  typedef struct packed {
    logic              start;
    logic [FldW-1:0]   dividend;
    logic [ExtW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FldW-1:0]   quotient;
    logic [ExtW-1:0]   remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/strided_tensor_address_generator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// strided_tensor_address_generator_unit: N-D strided address generator
// Keeps per-dimension extents and strides and translates element ordinals.
//
//   Channel   Ports                                      Handshake
//   command   opcode/dim_index/extent/byte_stride/ordinal start_i, busy_o
//   result    src_offset/dst_offset/status/is_contiguous  done_o strobe
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i           write enable
//
// A translation runs the bit-serial divider for each dimension (not for a zero
// extent) and the three-pass 32x16 multiplier that all dimensions share.
// Reset clears extents, strides and config at once; no clearing pass is needed.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// ---------------------------------------------------------------------------
module strided_tensor_address_generator_unit #(
  parameter int unsigned MAX_DIMS    = stag_pkg::MaxDimsDefault,
  parameter int unsigned OFFSET_BITS = stag_pkg::OffsetBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [1:0]                      opcode_i,
  input  wire logic [2:0]                      dim_index_i,
  input  wire logic [stag_pkg::ExtW-1:0]       extent_i,
  input  wire logic signed [stag_pkg::FldW-1:0] byte_stride_i,
  input  wire logic [stag_pkg::FldW-1:0]       ordinal_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [stag_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [stag_pkg::CfgW-1:0]       cfg_wdata_i,
  output logic                                 done_o,
  output logic signed [stag_pkg::FldW-1:0]     src_offset_o,
  output logic [stag_pkg::FldW-1:0]            dst_offset_o,
  output logic [1:0]                           status_o,
  output logic                                 is_contiguous_o
);

  localparam int unsigned EW = stag_pkg::ExtW;
  localparam int unsigned FW = stag_pkg::FldW;
  localparam int unsigned AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  // Internal arithmetic width: enough for an 48x48 product and some headroom.
  localparam int unsigned WW = 2 * FW + 2;
  localparam logic [WW-1:0] SMax = WW'((65'd1 << (OFFSET_BITS - 1)) - 65'd1);
  localparam logic [WW-1:0] UMax = WW'((65'd1 << OFFSET_BITS) - 65'd1);
  localparam logic [WW-1:0] SMax48 = WW'(48'h7FFF_FFFF_FFFF);
  localparam logic [WW-1:0] SLim = (SMax < SMax48) ? SMax : SMax48;
  localparam logic [4:0] MaxDimsV = 5'(MAX_DIMS);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MUL, S_ACC, S_CSTEP, S_DONE
  } state_e;

  state_e state_q;
  logic [EW-1:0] ext_q [MAX_DIMS];
  logic [FW-1:0] str_q [MAX_DIMS];
  logic [FW-1:0] exp_q [MAX_DIMS];
  logic [3:0]    dim_count_q;
  logic [1:0]    elog_q;
  logic [1:0]    op_q;
  logic [4:0]    i_q;
  logic [FW-1:0] ord_q;
  logic [FW-1:0] ord0_q;
  logic [EW-1:0] idx_q;
  logic [WW-1:0] acc_q;
  logic [WW-1:0] prod_q;
  logic [WW-1:0] s_q;
  logic [1:0]    mc_q;
  logic          ovf_q;
  logic          contig_q;

  stag_pkg::div_req_t div_req;
  stag_pkg::div_rsp_t div_rsp;

  stag_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic [AW-1:0]   cur;
  logic [EW-1:0]   cur_ext;
  logic [FW-1:0]   cur_str;
  logic [WW-1:0]   mag;
  logic            neg;
  logic [WW-1:0]   dst_w;
  logic [EW-1:0]   mul_a;
  logic [FW-1:0]   mul_b;
  logic [15:0]     mul_chunk;
  logic [EW+15:0]  mul_pp;

  assign cur     = AW'(i_q - 5'd1);
  assign cur_ext = ext_q[cur];
  assign cur_str = str_q[cur];
  assign neg     = cur_str[FW-1];
  assign mag     = neg ? WW'(-{{(WW-FW){1'b1}}, cur_str}) : WW'(cur_str);
  assign dst_w   = WW'(ord0_q) << elog_q;

  // Shared multiplier: a 32-bit operand times one 16-bit slice per pass.
  assign mul_a = (op_q == stag_pkg::OpXlate) ? idx_q : cur_ext;
  assign mul_b = (op_q == stag_pkg::OpXlate) ? mag[FW-1:0] : s_q[FW-1:0];

  always_comb begin
    case (mc_q)
      2'd0:    mul_chunk = mul_b[15:0];
      2'd1:    mul_chunk = mul_b[31:16];
      default: mul_chunk = mul_b[47:32];
    endcase
  end

  assign mul_pp = mul_a * mul_chunk;

  assign div_req.start    = (state_q == S_DIV) && (i_q != 5'd0) && (cur_ext != '0)
                            && !div_rsp.done && (prod_q == '0);
  assign div_req.dividend = ord_q;
  assign div_req.divisor  = cur_ext;

  // Sequencer: one dimension per pass, innermost first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      dim_count_q     <= '0;
      elog_q          <= '0;
      mc_q            <= '0;
      done_o          <= 1'b0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        ext_q[k] <= '0;
        str_q[k] <= '0;
      end
    end else begin
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == stag_pkg::RegDimCount) dim_count_q <= cfg_wdata_i;
        if (cfg_idx_i == stag_pkg::RegElemLog2) elog_q <= cfg_wdata_i[1:0];
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q         <= opcode_i;
            ord_q        <= ordinal_i;
            ord0_q       <= ordinal_i;
            i_q          <= {1'b0, dim_count_q};
            acc_q        <= '0;
            prod_q       <= '0;
            mc_q         <= '0;
            s_q          <= WW'(1) << elog_q;
            ovf_q        <= 1'b0;
            contig_q     <= 1'b1;
            src_offset_o <= '0;
            dst_offset_o <= '0;
            is_contiguous_o <= 1'b0;
            status_o     <= stag_pkg::StOk;
            if (opcode_i == stag_pkg::OpWrite) begin
              if (5'(dim_index_i) >= MaxDimsV) begin
                status_o <= stag_pkg::StDimErr;
              end else begin
                ext_q[AW'(dim_index_i)] <= extent_i;
                str_q[AW'(dim_index_i)] <= byte_stride_i;
              end
              state_q <= S_DONE;
            end else if ({1'b0, dim_count_q} > MaxDimsV) begin
              status_o <= stag_pkg::StDimErr;
              state_q  <= S_DONE;
            end else if (opcode_i == stag_pkg::OpXlate) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_CSTEP;
            end
          end
        end
        S_DIV: begin
          // prod_q doubles as a "divide issued" flag here.
          if (i_q == 5'd0) begin
            state_q <= S_DONE;
          end else if (cur_ext == '0) begin
            idx_q   <= '0;
            ord_q   <= '0;
            prod_q  <= '0;
            state_q <= S_MUL;
          end else if (div_req.start) begin
            prod_q <= WW'(1);
          end else if (div_rsp.done) begin
            idx_q   <= div_rsp.remainder;
            ord_q   <= div_rsp.quotient;
            prod_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // Three passes, one 16-bit slice of the wide operand each.
          prod_q <= prod_q + (WW'(mul_pp) << {mc_q, 4'b0000});
          if (mc_q == 2'd2) begin
            mc_q    <= '0;
            state_q <= S_ACC;
          end else begin
            mc_q <= mc_q + 2'd1;
          end
        end
        S_ACC: begin
          if (op_q == stag_pkg::OpXlate) begin
            // Product limit and signed running sum check.
            if (neg) begin
              if (prod_q > SMax + WW'(1)) ovf_q <= 1'b1;
              else if ($signed(acc_q) - $signed(prod_q) < -$signed(SMax) - 1) ovf_q <= 1'b1;
              acc_q <= acc_q - prod_q;
            end else begin
              if (prod_q > SMax) ovf_q <= 1'b1;
              else if ($signed(acc_q) + $signed(prod_q) > $signed(SMax)) ovf_q <= 1'b1;
              acc_q <= acc_q + prod_q;
            end
            prod_q  <= '0;
            i_q     <= i_q - 5'd1;
            state_q <= S_DIV;
          end else if (prod_q > UMax) begin
            // Running stride product leaves the offset range.
            status_o <= stag_pkg::StOverflow;
            state_q  <= S_DONE;
          end else begin
            s_q     <= prod_q;
            i_q     <= i_q - 5'd1;
            state_q <= S_CSTEP;
          end
        end
        S_CSTEP: begin
          if (i_q == 5'd0) begin
            if (op_q == stag_pkg::OpMake) begin
              for (int k = 0; k < MAX_DIMS; k++) begin
                if (5'(k) < {1'b0, dim_count_q}) str_q[k] <= exp_q[k];
              end
            end else begin
              is_contiguous_o <= contig_q;
            end
            state_q <= S_DONE;
          end else if (s_q > SLim) begin
            status_o <= stag_pkg::StOverflow;
            state_q  <= S_DONE;
          end else begin
            exp_q[cur] <= FW'(s_q);
            if (cur_str != FW'(s_q)) contig_q <= 1'b0;
            prod_q  <= '0;
            state_q <= S_MUL;
          end
        end
        S_DONE: begin
          if (op_q == stag_pkg::OpXlate && status_o == stag_pkg::StOk) begin
            if (ovf_q || dst_w > SMax || dst_w > WW'(48'hFFFF_FFFF_FFFF)) begin
              status_o <= stag_pkg::StOverflow;
            end else begin
              src_offset_o <= FW'(acc_q);
              dst_offset_o <= FW'(dst_w);
            end
          end
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_done_from_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == S_DONE) else $error("done without finish");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_contig_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_contiguous_o) |-> op_q == stag_pkg::OpCheck) else $error("bad contig");
`endif

endmodule
`default_nettype wire

// ===== rtl/stag_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// stag_divider: shared restoring divider
// Divides a 48-bit ordinal by a 32-bit extent, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module stag_divider (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  stag_pkg::div_req_t req_i,
  output stag_pkg::div_rsp_t rsp_o
);

  localparam int unsigned Qw = stag_pkg::FldW;
  localparam int unsigned Dw = stag_pkg::ExtW;
  localparam int unsigned CntW = $clog2(Qw + 1);

  logic [Qw-1:0]   quo_q, quo_d;
  logic [Dw:0]     rem_q, rem_d;
  logic [Dw-1:0]   dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [Dw+1:0]   trial;

  // One shift and subtract step; the trial value carries an extra sign bit so
  // that a shifted remainder at or above 2^Dw is still compared correctly.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {1'b0, rem_q[Dw-1:0], quo_q[Qw-1]} - {2'b00, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CntW'(Qw);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[Dw+1]) begin
        rem_d = trial[Dw:0];
        quo_d = {quo_q[Qw-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Dw-1:0], quo_q[Qw-1]};
        quo_d = {quo_q[Qw-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q[Dw-1:0];

endmodule
`default_nettype wire
